// ===== hw/rtl/grbc_pkg.sv =====
// Shared types, constants and table functions for the grid ray boundary caster.
package grbc_pkg;

   // Default parameter values
   localparam int TILE_PIXELS_DEF     = 64;
   localparam int MAP_ENTRIES_DEF     = 256;
   localparam int TAN_TABLE_DEPTH_DEF = 1024;
   localparam int MAX_STEPS_DEF       = 64;

   // Configuration register reset values
   localparam logic [9:0] SCREEN_WIDTH_RST  = 10'd640;
   localparam logic [9:0] SCREEN_HEIGHT_RST = 10'd480;
   localparam logic [4:0] MAP_COLUMNS_RST   = 5'd10;
   localparam logic [4:0] MAP_ROWS_RST      = 5'd8;

   // Configuration register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MAP_COLUMNS   = 2'd2;
   localparam logic [1:0] CSR_MAP_ROWS      = 2'd3;

   // Request commands
   localparam logic CMD_WRITE_TILE = 1'b0;
   localparam logic CMD_CAST       = 1'b1;

   // Tangent table format: unsigned Q6.8, saturated at 32.0
   localparam int               TAN_W      = 14;
   localparam logic [TAN_W-1:0] TAN_SAT_Q8 = 14'd8192;
   localparam logic [63:0]      Q30_ONE    = 64'd1073741824;
   localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;

   // Coordinate width inside the datapath
   localparam int COORD_W = 32;

   typedef struct packed {
      logic              command;
      logic [7:0]        tile_index;
      logic signed [7:0] tile_data;
      logic [17:0]       ray_x;
      logic [17:0]       ray_y;
      logic [15:0]       ray_angle;
      logic              side_select;
   } req_type;

   typedef struct packed {
      logic signed [19:0] hit_x;
      logic signed [19:0] hit_y;
      logic signed [7:0]  hit_tile;
      logic               left_screen;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ANGLE,
      S_ROM,
      S_MUL,
      S_INIT,
      S_ADDR,
      S_IDX,
      S_TEST,
      S_OUT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic map_write;
      logic ld_angle;
      logic ld_off;
      logic ld_mul;
      logic ld_init;
      logic ld_addr;
      logic ld_idx;
      logic ld_test;
      logic load_rsp;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic req_cast;
      logic tile_nz;
      logic off_screen;
      logic last_step;
      logic rsp_free;
   } dp_sts_type;

   // Shift-subtract division, used only to build constant tables
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul30(logic [63:0] a, logic [63:0] b);
      logic [63:0] p;
      p = a * b;
      return p >> 30;
   endfunction

   // Table entry k: tan(k*pi/(2*depth)) in Q6.8 from Q30 Taylor sine and cosine
   function automatic logic [TAN_W-1:0] tan_value(int unsigned k, int unsigned depth);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        r;
      logic [63:0]        s;
      logic signed [63:0] c;
      logic [63:0]        t;
      if (k >= depth) begin
         return TAN_SAT_Q8;
      end
      x  = udiv64(64'(k) * HALF_PI_Q30, 64'(depth));
      x2 = mul30(x, x);
      r  = Q30_ONE - x2 / 110;
      r  = Q30_ONE - mul30(x2, r) / 72;
      r  = Q30_ONE - mul30(x2, r) / 42;
      r  = Q30_ONE - mul30(x2, r) / 20;
      r  = Q30_ONE - mul30(x2, r) / 6;
      s  = mul30(x, r);
      r  = Q30_ONE - x2 / 132;
      r  = Q30_ONE - mul30(x2, r) / 90;
      r  = Q30_ONE - mul30(x2, r) / 56;
      r  = Q30_ONE - mul30(x2, r) / 30;
      r  = Q30_ONE - mul30(x2, r) / 12;
      c  = $signed(Q30_ONE) - $signed(mul30(x2, r) / 2);
      if (c <= 0) begin
         return TAN_SAT_Q8;
      end
      t = udiv64(s * 64'd256, 64'(c));
      if (t > 64'(TAN_SAT_Q8)) begin
         return TAN_SAT_Q8;
      end
      return t[TAN_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/grbc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module grbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/grbc_tan_rom.sv =====
// Tangent table ROM, Q6.8 entries, registered read.
module grbc_tan_rom #(
   parameter int DEPTH = grbc_pkg::TAN_TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic [$clog2(DEPTH+1)-1:0]     addr,
   output logic [grbc_pkg::TAN_W-1:0]     data
);
   import grbc_pkg::*;

   logic [TAN_W-1:0] rom [DEPTH+1];
   logic [TAN_W-1:0] data_ff;

   // Fill the table at elaboration
   for (genvar g = 0; g <= DEPTH; g++) begin : g_entry
      localparam logic [TAN_W-1:0] VALUE = tan_value(g, DEPTH);
      assign rom[g] = VALUE;
   end

   always_ff @(posedge clock) begin
      data_ff <= rom[addr];
   end

   assign data = data_ff;
endmodule

// ===== hw/rtl/grbc_ctrl.sv =====
// Controller state machine sequencing tile writes and ray casts.
module grbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  grbc_pkg::dp_sts_type sts,
   output grbc_pkg::dp_cmd_type cmd
);
   import grbc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (sts.req_cast) begin
                  cmd.capture = 1'b1;
                  state_in    = S_ANGLE;
               end else begin
                  cmd.map_write = 1'b1;
               end
            end
         end
         S_ANGLE: begin
            cmd.ld_angle = 1'b1;
            state_in     = S_ROM;
         end
         S_ROM: begin
            cmd.ld_off = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.ld_mul = 1'b1;
            state_in   = S_INIT;
         end
         S_INIT: begin
            cmd.ld_init = 1'b1;
            state_in    = S_ADDR;
         end
         S_ADDR: begin
            cmd.ld_addr = 1'b1;
            state_in    = S_IDX;
         end
         S_IDX: begin
            cmd.ld_idx = 1'b1;
            state_in   = S_TEST;
         end
         S_TEST: begin
            cmd.ld_test = 1'b1;
            if (sts.tile_nz || sts.off_screen || sts.last_step) begin
               state_in = S_OUT;
            end else begin
               state_in = S_ADDR;
            end
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A ray that neither hits, leaves nor reaches its last step keeps stepping
   a_keep_stepping: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST && !sts.tile_nz && !sts.off_screen && !sts.last_step)
      |=> state_ff == S_ADDR)
      else $error("ray stopped without cause");

   // A result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free)
      else $error("result register overwritten");
endmodule

// ===== hw/rtl/grbc_datapath.sv =====
// Datapath: configuration, angle and slope setup, tile stepping, map and result register.
module grbc_datapath #(
   parameter int TILE_PIXELS     = grbc_pkg::TILE_PIXELS_DEF,
   parameter int MAP_ENTRIES     = grbc_pkg::MAP_ENTRIES_DEF,
   parameter int TAN_TABLE_DEPTH = grbc_pkg::TAN_TABLE_DEPTH_DEF,
   parameter int MAX_STEPS       = grbc_pkg::MAX_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  grbc_pkg::req_type    req_item,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_wdata,
   input  grbc_pkg::dp_cmd_type cmd,
   output grbc_pkg::dp_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output grbc_pkg::rsp_type    rsp_item
);
   import grbc_pkg::*;

   localparam int D      = TAN_TABLE_DEPTH;
   localparam int UW     = $clog2(4 * D);
   localparam int KW     = $clog2(D + 1);
   localparam int AW     = $clog2(MAP_ENTRIES);
   localparam int IDX_W  = ($clog2(MAP_ENTRIES + 1) > 10) ? $clog2(MAP_ENTRIES + 1) : 10;
   localparam int SW     = $clog2(MAX_STEPS);
   localparam int DIV_SH = 22;
   localparam int RECIP  = ((1 << DIV_SH) + TILE_PIXELS - 1) / TILE_PIXELS;
   localparam logic signed [COORD_W-1:0] TILE_S  = COORD_W'(TILE_PIXELS);
   localparam logic signed [COORD_W-1:0] TILE8_S = COORD_W'(TILE_PIXELS * 256);
   localparam logic signed [COORD_W-1:0] HALF8_S = COORD_W'(TILE_PIXELS * 128);
   localparam logic [23:0] MAP_PIX_LIM = 24'(32 * TILE_PIXELS);

   // Quotient by the tile size for values below 32 tiles (reciprocal multiply)
   function automatic logic [12:0] tile_quot(logic [12:0] v);
      logic [33:0] p;
      p = 34'(v) * 34'(RECIP);
      return 13'(p >> DIV_SH);
   endfunction

   function automatic logic signed [19:0] clamp_out(logic signed [COORD_W-1:0] v);
      if (v > COORD_W'(524287)) begin
         return 20'sd524287;
      end else if (v < -COORD_W'(524288)) begin
         return -20'sd524288;
      end
      return v[19:0];
   endfunction

   // Configuration registers
   logic [9:0] scr_w_ff, scr_h_ff;
   logic [4:0] cols_ff, rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= SCREEN_WIDTH_RST;
         scr_h_ff <= SCREEN_HEIGHT_RST;
         cols_ff  <= MAP_COLUMNS_RST;
         rows_ff  <= MAP_ROWS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  scr_w_ff <= csr_wdata;
            CSR_SCREEN_HEIGHT: scr_h_ff <= csr_wdata;
            CSR_MAP_COLUMNS:   cols_ff  <= csr_wdata[4:0];
            CSR_MAP_ROWS:      rows_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Captured ray
   logic [17:0] cap_x_ff, cap_y_ff, cap_x_in, cap_y_in;
   logic [15:0] cap_ang_ff, cap_ang_in;
   logic        cap_vert_ff, cap_vert_in;

   // Angle stage
   logic [31:0]   ang_prod;
   logic [UW-1:0] u;
   logic [1:0]    quad;
   logic [KW-1:0] ang_i;
   logic [KW-1:0] k_ff, k_in;
   logic          odd_ff, odd_in, sin_pos_ff, sin_pos_in, cos_pos_ff, cos_pos_in;
   logic [17:0]   pv;
   logic [12:0]   oq_ff, oq_in;

   // Offset, slope products
   logic [15:0]              rem16;
   logic [16:0]              off_ff, off_in;
   logic [TAN_W-1:0]         rom_q;
   logic signed [TAN_W:0]    slope;
   logic signed [COORD_W-1:0] prod_ff, prod_in, bt_ff, bt_in;

   // Stepping state
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [COORD_W-1:0] lx_ff, lx_in, ly_ff, ly_in;
   logic signed [COORD_W-1:0] px_s, py_s, pfloor;
   logic [SW-1:0]             step_ff, step_in;

   // Lookup
   logic signed [COORD_W-1:0] xs, ys;
   logic [23:0]               vx, vy;
   logic [12:0]               colq, rowq;
   logic [4:0]                col_ff, col_in, row_ff, row_in;
   logic                      out_ff, out_in, in_map_ff, in_map_in;
   logic [IDX_W-1:0]          idx, wr_idx;
   logic [7:0]                ram_q;
   logic signed [7:0]         tile;
   logic signed [COORD_W-1:0] xmax, ymax;

   // Result
   logic signed [7:0] res_tile_ff, res_tile_in;
   logic              res_left_ff, res_left_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Angle quantisation and table address
   always_comb begin
      ang_prod = 32'(cap_ang_ff) * 32'(4 * D);
      u        = ang_prod[16 +: UW];
      if (u >= UW'(3 * D)) begin
         quad  = 2'd3;
         ang_i = KW'(u - UW'(3 * D));
      end else if (u >= UW'(2 * D)) begin
         quad  = 2'd2;
         ang_i = KW'(u - UW'(2 * D));
      end else if (u >= UW'(D)) begin
         quad  = 2'd1;
         ang_i = KW'(u - UW'(D));
      end else begin
         quad  = 2'd0;
         ang_i = KW'(u);
      end
      pv = cap_vert_ff ? cap_x_ff : cap_y_ff;
   end

   // Offset within the tile
   assign rem16 = 16'(pv[17:8]) - 16'(oq_ff) * 16'(TILE_PIXELS);

   // Signed slope from the table entry
   assign slope = odd_ff ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

   assign px_s   = $signed(COORD_W'(cap_x_ff));
   assign py_s   = $signed(COORD_W'(cap_y_ff));
   assign pfloor = prod_ff >>> 8;

   // Lookup point and map coordinates
   assign xs   = cx_ff + lx_ff;
   assign ys   = cy_ff + ly_ff;
   assign vx   = xs[31:8];
   assign vy   = ys[31:8];
   assign colq = tile_quot(vx[12:0]);
   assign rowq = tile_quot(vy[12:0]);
   assign idx  = IDX_W'(row_ff) * IDX_W'(cols_ff) + IDX_W'(col_ff);
   assign tile = in_map_ff ? $signed(ram_q) : 8'sd0;
   assign xmax = $signed(COORD_W'({scr_w_ff, 8'd0}));
   assign ymax = $signed(COORD_W'({scr_h_ff, 8'd0}));

   // Status to the controller
   always_comb begin
      sts.req_cast   = (req_item.command == CMD_CAST);
      sts.tile_nz    = (tile != 8'sd0);
      sts.off_screen = cx_ff[COORD_W-1] || (cx_ff > xmax) || cy_ff[COORD_W-1] || (cy_ff > ymax);
      sts.last_step  = (step_ff == SW'(MAX_STEPS - 1));
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Next values
   always_comb begin
      cap_x_in    = cap_x_ff;
      cap_y_in    = cap_y_ff;
      cap_ang_in  = cap_ang_ff;
      cap_vert_in = cap_vert_ff;
      k_in        = k_ff;
      odd_in      = odd_ff;
      sin_pos_in  = sin_pos_ff;
      cos_pos_in  = cos_pos_ff;
      oq_in       = oq_ff;
      off_in      = off_ff;
      prod_in     = prod_ff;
      bt_in       = bt_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      lx_in       = lx_ff;
      ly_in       = ly_ff;
      step_in     = step_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      out_in      = out_ff;
      in_map_in   = in_map_ff;
      res_tile_in = res_tile_ff;
      res_left_in = res_left_ff;
      rsp_in      = rsp_ff;

      // Hold the cast request
      if (cmd.capture) begin
         cap_x_in    = req_item.ray_x;
         cap_y_in    = req_item.ray_y;
         cap_ang_in  = req_item.ray_angle;
         cap_vert_in = req_item.side_select;
      end

      // Quadrant, table address, tile quotient of the origin
      if (cmd.ld_angle) begin
         odd_in     = quad[0];
         sin_pos_in = !quad[1];
         cos_pos_in = (quad == 2'd0) || (quad == 2'd3);
         k_in       = (cap_vert_ff == quad[0]) ? KW'(D) - ang_i : ang_i;
         oq_in      = tile_quot(13'(pv[17:8]));
      end

      if (cmd.ld_off) begin
         off_in = {rem16[8:0], pv[7:0]};
      end

      // Offset times slope, tile times slope
      if (cmd.ld_mul) begin
         prod_in = $signed(COORD_W'(off_ff)) * COORD_W'(slope);
         bt_in   = COORD_W'(slope) * TILE_S;
      end

      // First crossing and step vector
      if (cmd.ld_init) begin
         step_in = '0;
         if (!cap_vert_ff) begin
            cy_in = py_s - $signed(COORD_W'(off_ff));
            cx_in = px_s + pfloor;
            lx_in = '0;
            if (sin_pos_ff) begin
               ax_in = bt_ff;
               ay_in = -TILE8_S;
               ly_in = -HALF8_S;
            end else begin
               cy_in = py_s - $signed(COORD_W'(off_ff)) + TILE8_S;
               cx_in = px_s + pfloor - bt_ff;
               ax_in = -bt_ff;
               ay_in = TILE8_S;
               ly_in = HALF8_S;
            end
         end else begin
            cx_in = px_s - $signed(COORD_W'(off_ff));
            cy_in = py_s + pfloor;
            ly_in = '0;
            if (cos_pos_ff) begin
               cy_in = py_s + pfloor - bt_ff;
               cx_in = px_s - $signed(COORD_W'(off_ff)) + TILE8_S;
               ax_in = TILE8_S;
               ay_in = -bt_ff;
               lx_in = HALF8_S;
            end else begin
               ax_in = -TILE8_S;
               ay_in = bt_ff;
               lx_in = -HALF8_S;
            end
         end
      end

      // Tile column and row of the lookup point
      if (cmd.ld_addr) begin
         col_in = colq[4:0];
         row_in = rowq[4:0];
         out_in = xs[COORD_W-1] || ys[COORD_W-1] || (vx >= MAP_PIX_LIM) || (vy >= MAP_PIX_LIM);
      end

      if (cmd.ld_idx) begin
         in_map_in = !out_ff && (col_ff < cols_ff) && (row_ff < rows_ff)
                     && (idx < IDX_W'(MAP_ENTRIES));
      end

      // Stop on a wall or the screen edge, else advance one tile
      if (cmd.ld_test) begin
         res_tile_in = 8'sd0;
         res_left_in = 1'b0;
         if (sts.tile_nz) begin
            res_tile_in = tile;
         end else if (sts.off_screen) begin
            res_left_in = 1'b1;
         end else begin
            cx_in   = cx_ff + ax_ff;
            cy_in   = cy_ff + ay_ff;
            step_in = step_ff + SW'(1);
         end
      end

      if (cmd.load_rsp) begin
         rsp_in.hit_x       = clamp_out(cx_ff);
         rsp_in.hit_y       = clamp_out(cy_ff);
         rsp_in.hit_tile    = res_tile_ff;
         rsp_in.left_screen = res_left_ff;
      end

      // Result register valid flag
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_x_ff    <= cap_x_in;
      cap_y_ff    <= cap_y_in;
      cap_ang_ff  <= cap_ang_in;
      cap_vert_ff <= cap_vert_in;
      k_ff        <= k_in;
      odd_ff      <= odd_in;
      sin_pos_ff  <= sin_pos_in;
      cos_pos_ff  <= cos_pos_in;
      oq_ff       <= oq_in;
      off_ff      <= off_in;
      prod_ff     <= prod_in;
      bt_ff       <= bt_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      lx_ff       <= lx_in;
      ly_ff       <= ly_in;
      step_ff     <= step_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      out_ff      <= out_in;
      in_map_ff   <= in_map_in;
      res_tile_ff <= res_tile_in;
      res_left_ff <= res_left_in;
      rsp_ff      <= rsp_in;
   end

   // Tangent table
   grbc_tan_rom #(
      .DEPTH (D)
   ) u_tan_rom (
      .clock (clock),
      .addr  (k_ff),
      .data  (rom_q)
   );

   // Map store
   assign wr_idx = IDX_W'(req_item.tile_index);

   grbc_ram #(
      .WIDTH (8),
      .DEPTH (MAP_ENTRIES)
   ) u_map_ram (
      .clock (clock),
      .we    (cmd.map_write && (wr_idx < IDX_W'(MAP_ENTRIES))),
      .waddr (wr_idx[AW-1:0]),
      .wdata (req_item.tile_data),
      .raddr (idx[AW-1:0]),
      .rdata (ram_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A loaded result shows as valid next cycle
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not valid");

   // A result is never both a hit and an exit
   a_hit_or_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.left_screen && (rsp_ff.hit_tile != 8'sd0)))
      else $error("result flags both hit and exit");
endmodule

// ===== hw/rtl/grid_ray_boundary_cast.sv =====
// A tile write is done in the idle state; a cast runs setup, then the step loop once for each tile looked up.
// At most MAX_STEPS tiles are looked up per cast.
// The step loop is address, index multiply with registered map RAM read, then tile test.
// One item at a time; the next is taken the cycle after a result enters the output register.
// Reset is synchronous: state to idle, output empty, configuration registers to defaults; map not cleared.
module grid_ray_boundary_cast #(
   parameter int TILE_PIXELS     = grbc_pkg::TILE_PIXELS_DEF,
   parameter int MAP_ENTRIES     = grbc_pkg::MAP_ENTRIES_DEF,
   parameter int TAN_TABLE_DEPTH = grbc_pkg::TAN_TABLE_DEPTH_DEF,
   parameter int MAX_STEPS       = grbc_pkg::MAX_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  grbc_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grbc_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_wdata
);
   import grbc_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   grbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   grbc_datapath #(
      .TILE_PIXELS     (TILE_PIXELS),
      .MAP_ENTRIES     (MAP_ENTRIES),
      .TAN_TABLE_DEPTH (TAN_TABLE_DEPTH),
      .MAX_STEPS       (MAX_STEPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );
endmodule
